/* rtl/core/srrip_stream_detect_replacement_core_macros.svh */
// Assertion helpers, clocked on i_clk and disabled in reset.
`ifndef SRRIP_STREAM_DETECT_REPLACEMENT_CORE_MACROS_SVH
`define SRRIP_STREAM_DETECT_REPLACEMENT_CORE_MACROS_SVH

`define SRSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define SRSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/srsd_pkg.sv */
`timescale 1ns / 1ps
package srsd_pkg;

    localparam int SET_IDX_W = 11;
    localparam int WAY_IDX_W = 4;
    localparam int IN_ADDR_W = 48;
    localparam int VICTIM_W  = 4;

    localparam int STRIDE_W    = 13;
    localparam int THRESH_W    = 2;
    localparam int PERIOD_W    = 17;
    localparam int FILL_CNT_W  = 16;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic [1:0] REG_STRIDE    = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_PERIOD    = 2'd2;

    localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd64;
    localparam logic [THRESH_W-1:0] THRESH_RST = 2'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 17'd8192;

    localparam logic CMD_VICTIM = 1'b0;

    typedef enum logic [1:0] {
        OP_VICTIM,
        OP_HIT,
        OP_FILL
    } t_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_DECAY_RD,
        ST_DECAY_WR
    } t_bstate;

    typedef struct packed {
        logic [STRIDE_W-1:0] stride_bytes;
        logic [THRESH_W-1:0] stream_threshold;
        logic [PERIOD_W-1:0] fill_period;
    } t_cfg;

endpackage

/* rtl/core/srsd_ram.sv */
`timescale 1ns / 1ps
module srsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/srsd_front.sv */
`timescale 1ns / 1ps
module srsd_front #(
    parameter int NUM_SETS   = 2048,
    parameter int NUM_WAYS   = 16,
    parameter int ADDR_WIDTH = 48
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic                                       i_command,
    input  logic [srsd_pkg::SET_IDX_W-1:0]             i_set_index,
    input  logic [srsd_pkg::WAY_IDX_W-1:0]             i_way_index,
    input  logic [srsd_pkg::IN_ADDR_W-1:0]             i_address,
    input  logic                                       i_was_hit,
    input  logic                                       i_hold,
    output logic                                       o_head_valid,
    output srsd_pkg::t_op                              o_head_op,
    output logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] o_head_set,
    output logic [$clog2(NUM_WAYS)-1:0]                o_head_way,
    output logic [ADDR_WIDTH-1:0]                      o_head_addr,
    input  logic                                       i_pop
);

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = $clog2(NUM_WAYS);
    localparam int QD    = 2;
    localparam longint unsigned SET_RECIP =
        ((64'd1 << 32) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);
    localparam longint unsigned WAY_RECIP =
        ((64'd1 << 16) + 64'(NUM_WAYS) - 64'd1) / 64'(NUM_WAYS);

    srsd_pkg::t_op      r_q_op   [QD];
    logic [SET_W-1:0]   r_q_set  [QD];
    logic [WAY_W-1:0]   r_q_way  [QD];
    logic [ADDR_WIDTH-1:0] r_q_addr [QD];
    logic               r_wptr, n_wptr;
    logic               r_rptr, n_rptr;
    logic [1:0]         r_count, n_count;

    logic               push;
    srsd_pkg::t_op      c_op;
    logic [srsd_pkg::SET_IDX_W+32:0] set_prod;
    logic [srsd_pkg::SET_IDX_W-1:0]  set_quo;
    logic [31:0]                     set_full;
    logic [srsd_pkg::WAY_IDX_W+16:0] way_prod;
    logic [srsd_pkg::WAY_IDX_W-1:0]  way_quo;
    logic [7:0]                      way_full;
    logic [63:0]        addr_ext;

    // set and way reduced modulo the geometry by reciprocal multiplication
    always_comb begin
        set_prod = (srsd_pkg::SET_IDX_W + 33)'(i_set_index)
                 * (srsd_pkg::SET_IDX_W + 33)'(SET_RECIP);
        set_quo  = set_prod[srsd_pkg::SET_IDX_W+31:32];
        set_full = 32'(i_set_index) - 32'(set_quo) * 32'(NUM_SETS);
        way_prod = (srsd_pkg::WAY_IDX_W + 17)'(i_way_index)
                 * (srsd_pkg::WAY_IDX_W + 17)'(WAY_RECIP);
        way_quo  = way_prod[srsd_pkg::WAY_IDX_W+15:16];
        way_full = 8'(i_way_index) - 8'(way_quo) * 8'(NUM_WAYS);
    end

    always_comb begin
        if (i_command == srsd_pkg::CMD_VICTIM) begin
            c_op = srsd_pkg::OP_VICTIM;
        end else if (i_was_hit) begin
            c_op = srsd_pkg::OP_HIT;
        end else begin
            c_op = srsd_pkg::OP_FILL;
        end
    end

    assign addr_ext   = 64'(i_address);
    assign o_in_stall = (r_count == 2'(QD)) || i_hold;
    assign push       = i_in_valid && !o_in_stall;

    assign o_head_valid = (r_count != 2'd0);
    assign o_head_op    = r_q_op[r_rptr];
    assign o_head_set   = r_q_set[r_rptr];
    assign o_head_way   = r_q_way[r_rptr];
    assign o_head_addr  = r_q_addr[r_rptr];

    always_comb begin
        n_wptr  = push  ? ~r_wptr : r_wptr;
        n_rptr  = i_pop ? ~r_rptr : r_rptr;
        n_count = r_count + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_op[r_wptr]   <= c_op;
            r_q_set[r_wptr]  <= set_full[SET_W-1:0];
            r_q_way[r_wptr]  <= way_full[WAY_W-1:0];
            r_q_addr[r_wptr] <= addr_ext[ADDR_WIDTH-1:0];
        end
    end

endmodule

/* rtl/core/srsd_back.sv */
`timescale 1ns / 1ps
module srsd_back #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int RRPV_WIDTH    = 2,
    parameter int COUNTER_WIDTH = 2,
    parameter int ADDR_WIDTH    = 48
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  srsd_pkg::t_cfg                             i_cfg,
    input  logic                                       i_head_valid,
    input  srsd_pkg::t_op                              i_head_op,
    input  logic [(NUM_SETS > 1 ? $clog2(NUM_SETS) : 1)-1:0] i_head_set,
    input  logic [$clog2(NUM_WAYS)-1:0]                i_head_way,
    input  logic [ADDR_WIDTH-1:0]                      i_head_addr,
    output logic                                       o_pop,
    output logic                                       o_clearing,
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic [srsd_pkg::VICTIM_W-1:0]              o_victim_way
);

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SLOT_W = SET_W + WAY_W;
    localparam int SLOTS  = NUM_SETS * (2 ** WAY_W);
    localparam int RROW_W = NUM_WAYS * RRPV_WIDTH;
    localparam int CROW_W = NUM_WAYS * COUNTER_WIDTH;
    localparam logic [RRPV_WIDTH-1:0]    RRPV_TOP = '1;
    localparam logic [COUNTER_WIDTH-1:0] CNT_TOP  = '1;

    srsd_pkg::t_bstate r_state, n_state;
    srsd_pkg::t_op     r_op, n_op;
    logic [SET_W-1:0]  r_set, n_set;
    logic [WAY_W-1:0]  r_way, n_way;
    logic [ADDR_WIDTH-1:0] r_addr, n_addr;
    logic [SLOT_W-1:0] r_clr_ptr, n_clr_ptr;
    logic [SET_W-1:0]  r_dec_ptr, n_dec_ptr;
    logic [srsd_pkg::FILL_CNT_W-1:0] r_fill_cnt, n_fill_cnt;
    logic              r_out_valid, n_out_valid;
    logic [srsd_pkg::VICTIM_W-1:0] r_out_way, n_out_way;

    logic [SET_W-1:0]  rd_set;
    logic [WAY_W-1:0]  rd_way;
    logic              rr_we, cn_we, ad_we;
    logic [SET_W-1:0]  rr_waddr, cn_waddr;
    logic [SLOT_W-1:0] ad_waddr;
    logic [RROW_W-1:0] rr_wdata, rr_rdata;
    logic [CROW_W-1:0] cn_wdata, cn_rdata;
    logic [ADDR_WIDTH-1:0] ad_wdata, ad_rdata;

    logic [RRPV_WIDTH-1:0] hi, lift;
    logic [WAY_W-1:0]      victim;
    logic [RROW_W-1:0]     rr_aged, rr_zero, rr_fill;
    logic [CROW_W-1:0]     cn_hit, cn_fill, cn_decay;
    logic [COUNTER_WIDTH-1:0] c_old;
    logic [ADDR_WIDTH-1:0] d_ab, d_ba, delta;
    logic                  step, streaming, out_free, decay_now;
    logic [srsd_pkg::PERIOD_W-1:0] fill_next;

    srsd_ram #(.WIDTH(RROW_W), .DEPTH(NUM_SETS)) u_rrpv_ram (
        .i_clk(i_clk), .i_we(rr_we), .i_waddr(rr_waddr), .i_wdata(rr_wdata),
        .i_raddr(rd_set), .o_rdata(rr_rdata)
    );

    srsd_ram #(.WIDTH(CROW_W), .DEPTH(NUM_SETS)) u_cnt_ram (
        .i_clk(i_clk), .i_we(cn_we), .i_waddr(cn_waddr), .i_wdata(cn_wdata),
        .i_raddr(rd_set), .o_rdata(cn_rdata)
    );

    srsd_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(SLOTS)) u_addr_ram (
        .i_clk(i_clk), .i_we(ad_we), .i_waddr(ad_waddr), .i_wdata(ad_wdata),
        .i_raddr({rd_set, rd_way}), .o_rdata(ad_rdata)
    );

    // victim: age the set by the gap to the top, first way at the old maximum
    always_comb begin
        hi = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (rr_rdata[w*RRPV_WIDTH +: RRPV_WIDTH] > hi) begin
                hi = rr_rdata[w*RRPV_WIDTH +: RRPV_WIDTH];
            end
        end
        lift   = RRPV_TOP - hi;
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rr_rdata[w*RRPV_WIDTH +: RRPV_WIDTH] == hi) begin
                victim = WAY_W'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++) begin
            rr_aged[w*RRPV_WIDTH +: RRPV_WIDTH] = rr_rdata[w*RRPV_WIDTH +: RRPV_WIDTH] + lift;
        end
    end

    always_comb begin
        c_old = cn_rdata[r_way*COUNTER_WIDTH +: COUNTER_WIDTH];
        d_ab  = r_addr - ad_rdata;
        d_ba  = ad_rdata - r_addr;
        if (ad_rdata == '0) begin
            delta = '0;
        end else if (r_addr >= ad_rdata) begin
            delta = d_ab;
        end else begin
            delta = d_ba;
        end
        step      = (delta == ADDR_WIDTH'(i_cfg.stride_bytes));
        streaming = (4'(c_old) >= 4'(i_cfg.stream_threshold));

        rr_zero = rr_rdata;
        rr_zero[r_way*RRPV_WIDTH +: RRPV_WIDTH] = '0;
        rr_fill = rr_rdata;
        rr_fill[r_way*RRPV_WIDTH +: RRPV_WIDTH] = streaming ? RRPV_TOP : '0;

        cn_hit = cn_rdata;
        if (step) begin
            if (c_old != CNT_TOP) begin
                cn_hit[r_way*COUNTER_WIDTH +: COUNTER_WIDTH] = c_old + 1'b1;
            end
        end else if (c_old != '0) begin
            cn_hit[r_way*COUNTER_WIDTH +: COUNTER_WIDTH] = c_old - 1'b1;
        end
        cn_fill = cn_rdata;
        cn_fill[r_way*COUNTER_WIDTH +: COUNTER_WIDTH] = '0;

        for (int w = 0; w < NUM_WAYS; w++) begin
            cn_decay[w*COUNTER_WIDTH +: COUNTER_WIDTH] =
                (cn_rdata[w*COUNTER_WIDTH +: COUNTER_WIDTH] != '0) ?
                cn_rdata[w*COUNTER_WIDTH +: COUNTER_WIDTH] - 1'b1 :
                cn_rdata[w*COUNTER_WIDTH +: COUNTER_WIDTH];
        end

        fill_next = srsd_pkg::PERIOD_W'(r_fill_cnt) + 1'b1;
        decay_now = (fill_next >= i_cfg.fill_period);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_set       = r_set;
        n_way       = r_way;
        n_addr      = r_addr;
        n_clr_ptr   = r_clr_ptr;
        n_dec_ptr   = r_dec_ptr;
        n_fill_cnt  = r_fill_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_way   = r_out_way;
        o_pop       = 1'b0;
        rd_set      = r_set;
        rd_way      = r_way;
        rr_we       = 1'b0;
        cn_we       = 1'b0;
        ad_we       = 1'b0;
        rr_waddr    = r_set;
        cn_waddr    = r_set;
        ad_waddr    = {r_set, r_way};
        rr_wdata    = rr_rdata;
        cn_wdata    = cn_rdata;
        ad_wdata    = r_addr;

        unique case (r_state)
            srsd_pkg::ST_CLEAR: begin
                rr_we    = 1'b1;
                cn_we    = 1'b1;
                ad_we    = 1'b1;
                rr_waddr = r_clr_ptr[SLOT_W-1:WAY_W];
                cn_waddr = r_clr_ptr[SLOT_W-1:WAY_W];
                ad_waddr = r_clr_ptr;
                rr_wdata = '1;
                cn_wdata = '0;
                ad_wdata = '0;
                n_clr_ptr = r_clr_ptr + 1'b1;
                if (r_clr_ptr == SLOT_W'(SLOTS - 1)) begin
                    n_state = srsd_pkg::ST_IDLE;
                end
            end
            srsd_pkg::ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_head_op;
                    n_set   = i_head_set;
                    n_way   = i_head_way;
                    n_addr  = i_head_addr;
                    rd_set  = i_head_set;
                    rd_way  = i_head_way;
                    n_state = srsd_pkg::ST_EXEC;
                end
            end
            srsd_pkg::ST_EXEC: begin
                unique case (r_op)
                    srsd_pkg::OP_VICTIM: begin
                        if (out_free) begin
                            rr_we       = 1'b1;
                            rr_wdata    = rr_aged;
                            n_out_valid = 1'b1;
                            n_out_way   = srsd_pkg::VICTIM_W'(victim);
                            n_state     = srsd_pkg::ST_IDLE;
                        end
                    end
                    srsd_pkg::OP_HIT: begin
                        rr_we    = 1'b1;
                        cn_we    = 1'b1;
                        ad_we    = 1'b1;
                        rr_wdata = rr_zero;
                        cn_wdata = cn_hit;
                        n_state  = srsd_pkg::ST_IDLE;
                    end
                    srsd_pkg::OP_FILL: begin
                        rr_we    = 1'b1;
                        cn_we    = 1'b1;
                        ad_we    = 1'b1;
                        rr_wdata = rr_fill;
                        cn_wdata = cn_fill;
                        n_dec_ptr = '0;
                        if (decay_now) begin
                            n_fill_cnt = '0;
                            n_state    = srsd_pkg::ST_DECAY_RD;
                        end else begin
                            n_fill_cnt = fill_next[srsd_pkg::FILL_CNT_W-1:0];
                            n_state    = srsd_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = srsd_pkg::ST_IDLE;
                    end
                endcase
            end
            srsd_pkg::ST_DECAY_RD: begin
                rd_set  = r_dec_ptr;
                n_state = srsd_pkg::ST_DECAY_WR;
            end
            srsd_pkg::ST_DECAY_WR: begin
                rd_set   = r_dec_ptr;
                cn_we    = 1'b1;
                cn_waddr = r_dec_ptr;
                cn_wdata = cn_decay;
                if (r_dec_ptr == SET_W'(NUM_SETS - 1)) begin
                    n_state = srsd_pkg::ST_IDLE;
                end else begin
                    n_dec_ptr = r_dec_ptr + 1'b1;
                    n_state   = srsd_pkg::ST_DECAY_RD;
                end
            end
            default: begin
                n_state = srsd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srsd_pkg::ST_CLEAR;
            r_clr_ptr   <= '0;
            r_dec_ptr   <= '0;
            r_fill_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_ptr   <= n_clr_ptr;
            r_dec_ptr   <= n_dec_ptr;
            r_fill_cnt  <= n_fill_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_set     <= n_set;
        r_way     <= n_way;
        r_addr    <= n_addr;
        r_out_way <= n_out_way;
    end

    assign o_clearing   = (r_state == srsd_pkg::ST_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_out_way;

endmodule

/* rtl/core/srrip_stream_detect_replacement_core.sv */
`timescale 1ns / 1ps
// channel   valid        stall        payload
// request   i_in_valid   o_in_stall   i_command i_set_index i_way_index i_address i_was_hit
// result    o_out_valid  i_out_stall  o_victim_way
// config    psel/penable pready       paddr pwrite pwdata prdata
//
// Each request reads the set rows in ST_IDLE, then modifies and writes them back in ST_EXEC.
// A fill that ends a decay period walks every set, reading it in ST_DECAY_RD and writing it back in ST_DECAY_WR.
// After reset a clearing pass writes one slot a cycle over all NUM_SETS * 2**clog2(NUM_WAYS)
// slots, with o_in_stall high.
// A two-entry request queue keeps accepting until full while a victim result waits on i_out_stall.
module srrip_stream_detect_replacement_core #(
    parameter int NUM_SETS      = 2048,
    parameter int NUM_WAYS      = 16,
    parameter int RRPV_WIDTH    = 2,
    parameter int COUNTER_WIDTH = 2,
    parameter int ADDR_WIDTH    = 48
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [srsd_pkg::SET_IDX_W-1:0]      i_set_index,
    input  logic [srsd_pkg::WAY_IDX_W-1:0]      i_way_index,
    input  logic [srsd_pkg::IN_ADDR_W-1:0]      i_address,
    input  logic                                i_was_hit,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [srsd_pkg::VICTIM_W-1:0]       o_victim_way,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [srsd_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [srsd_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [srsd_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

`include "srrip_stream_detect_replacement_core_macros.svh"

    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W = $clog2(NUM_WAYS);

    srsd_pkg::t_cfg    r_cfg, n_cfg;
    logic              cfg_wr;
    logic              w_head_valid, w_pop, w_clearing;
    srsd_pkg::t_op     w_head_op;
    logic [SET_W-1:0]  w_head_set;
    logic [WAY_W-1:0]  w_head_way;
    logic [ADDR_WIDTH-1:0] w_head_addr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                srsd_pkg::REG_STRIDE:
                    n_cfg.stride_bytes = pwdata[srsd_pkg::STRIDE_W-1:0];
                srsd_pkg::REG_THRESHOLD:
                    n_cfg.stream_threshold = pwdata[srsd_pkg::THRESH_W-1:0];
                srsd_pkg::REG_PERIOD:
                    n_cfg.fill_period = pwdata[srsd_pkg::PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            srsd_pkg::REG_STRIDE:    prdata = srsd_pkg::CFG_DATA_W'(r_cfg.stride_bytes);
            srsd_pkg::REG_THRESHOLD: prdata = srsd_pkg::CFG_DATA_W'(r_cfg.stream_threshold);
            srsd_pkg::REG_PERIOD:    prdata = srsd_pkg::CFG_DATA_W'(r_cfg.fill_period);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stride_bytes     <= srsd_pkg::STRIDE_RST;
            r_cfg.stream_threshold <= srsd_pkg::THRESH_RST;
            r_cfg.fill_period      <= srsd_pkg::PERIOD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    srsd_front #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .ADDR_WIDTH(ADDR_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_set_index (i_set_index),
        .i_way_index (i_way_index),
        .i_address   (i_address),
        .i_was_hit   (i_was_hit),
        .i_hold      (w_clearing),
        .o_head_valid(w_head_valid),
        .o_head_op   (w_head_op),
        .o_head_set  (w_head_set),
        .o_head_way  (w_head_way),
        .o_head_addr (w_head_addr),
        .i_pop       (w_pop)
    );

    srsd_back #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .RRPV_WIDTH(RRPV_WIDTH),
        .COUNTER_WIDTH(COUNTER_WIDTH), .ADDR_WIDTH(ADDR_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head_valid(w_head_valid),
        .i_head_op   (w_head_op),
        .i_head_set  (w_head_set),
        .i_head_way  (w_head_way),
        .i_head_addr (w_head_addr),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_victim_way(o_victim_way)
    );

    `SRSD_ASSERT(a_clear_blocks_input, !w_clearing || o_in_stall, "request accepted while clearing")
    `SRSD_ASSERT(a_pop_needs_head, !w_pop || w_head_valid, "queue popped while empty")
    `SRSD_ASSERT_NEXT(a_clear_once, !w_clearing, !w_clearing, "clearing pass restarted")
    `SRSD_ASSERT_NEXT(a_no_pop_while_clear, w_clearing, !w_pop || !$past(w_clearing), "pop during clear")

endmodule

/* tb/srrip_stream_detect_replacement_core_checker.sv */
`timescale 1ns / 1ps
module srrip_stream_detect_replacement_core_checker
    import srsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_command,
    input  logic [SET_IDX_W-1:0]  i_set_index,
    input  logic [WAY_IDX_W-1:0]  i_way_index,
    input  logic [IN_ADDR_W-1:0]  i_address,
    input  logic                  i_was_hit,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [VICTIM_W-1:0]   i_victim_way,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_victims_checked,
    output int                    o_requests
);
    localparam int N_SETS  = 2048;
    localparam int N_WAYS  = 16;
    localparam int N_SLOTS = N_SETS * N_WAYS;
    localparam logic [1:0] RRPV_FAR = 2'd3;
    localparam logic [1:0] CNT_MAX  = 2'd3;

    logic [1:0]           rrpv_mem [N_SLOTS];
    logic [1:0]           strm_ctr [N_SLOTS];
    logic [IN_ADDR_W-1:0] seen_addr [N_SLOTS];
    logic [FILL_CNT_W-1:0] fills_since_decay;
    t_cfg                 cfg;
    logic [VICTIM_W-1:0]  victim_q [$];

    initial begin
        for (int i = 0; i < N_SLOTS; i++) begin
            rrpv_mem[i] = RRPV_FAR;
            strm_ctr[i] = '0;
            seen_addr[i] = '0;
        end
        fills_since_decay = '0;
        cfg.stride_bytes = STRIDE_RST;
        cfg.stream_threshold = THRESH_RST;
        cfg.fill_period = PERIOD_RST;
        o_fail_count = 0;
        o_victims_checked = 0;
        o_requests = 0;
    end

    assign o_pending = victim_q.size();

    function automatic logic [VICTIM_W-1:0] choose_victim(int base);
        logic [1:0] hi;
        logic [1:0] lift;
        hi = '0;
        for (int w = 0; w < N_WAYS; w++)
            if (rrpv_mem[base + w] > hi) hi = rrpv_mem[base + w];
        if (hi < RRPV_FAR) begin
            lift = RRPV_FAR - hi;
            for (int w = 0; w < N_WAYS; w++) rrpv_mem[base + w] += lift;
        end
        for (int w = 0; w < N_WAYS; w++)
            if (rrpv_mem[base + w] == RRPV_FAR) return VICTIM_W'(w);
        return '0;
    endfunction

    function automatic void apply_update(int slot, logic [IN_ADDR_W-1:0] addr, logic hit);
        logic [IN_ADDR_W-1:0] prev;
        logic [IN_ADDR_W-1:0] delta;
        logic                 streaming;
        logic [31:0]          next_fills;
        if (hit) begin
            prev = seen_addr[slot];
            delta = '0;
            if (prev != 0) delta = (addr >= prev) ? addr - prev : prev - addr;
            if (delta == IN_ADDR_W'(cfg.stride_bytes)) begin
                if (strm_ctr[slot] < CNT_MAX) strm_ctr[slot]++;
            end else if (strm_ctr[slot] > 0) begin
                strm_ctr[slot]--;
            end
            seen_addr[slot] = addr;
            rrpv_mem[slot] = '0;
        end else begin
            streaming = {30'd0, strm_ctr[slot]} >= {30'd0, cfg.stream_threshold};
            next_fills = 32'(fills_since_decay) + 1;
            if (next_fills >= 32'(cfg.fill_period)) begin
                fills_since_decay = '0;
                for (int i = 0; i < N_SLOTS; i++)
                    if (strm_ctr[i] > 0) strm_ctr[i]--;
            end else begin
                fills_since_decay = next_fills[FILL_CNT_W-1:0];
            end
            rrpv_mem[slot] = streaming ? RRPV_FAR : 2'd0;
            strm_ctr[slot] = '0;
            seen_addr[slot] = addr;
        end
    endfunction

    always @(posedge i_clk) begin
        int base;
        logic [VICTIM_W-1:0] want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_STRIDE:    cfg.stride_bytes = pwdata[STRIDE_W-1:0];
                    REG_THRESHOLD: cfg.stream_threshold = pwdata[THRESH_W-1:0];
                    REG_PERIOD:    cfg.fill_period = pwdata[PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (victim_q.size() == 0) begin
                    $error("victim_way: no request pending, got %0d", i_victim_way);
                    o_fail_count++;
                end else begin
                    want = victim_q.pop_front();
                    o_victims_checked++;
                    if (i_victim_way !== want) begin
                        $error("victim_way: expected %0d, got %0d", want, i_victim_way);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_requests++;
                base = int'(i_set_index) * N_WAYS;
                if (i_command == CMD_VICTIM)
                    victim_q.push_back(choose_victim(base));
                else
                    apply_update(base + int'(i_way_index), i_address, i_was_hit);
            end
        end
    end
endmodule

/* tb/srrip_stream_detect_replacement_core_tb.sv */
`timescale 1ns / 1ps
module srrip_stream_detect_replacement_core_tb;
    import srsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 13000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_command;
    logic [SET_IDX_W-1:0]  i_set_index;
    logic [WAY_IDX_W-1:0]  i_way_index;
    logic [IN_ADDR_W-1:0]  i_address;
    logic                  i_was_hit;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [VICTIM_W-1:0]   o_victim_way;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int victims_checked;
    int requests;
    int idle_cycles;
    int stall_mode;
    int phase_count;
    logic [STRIDE_W-1:0] cur_stride;
    logic [IN_ADDR_W-1:0] sent_addr [int];

    srrip_stream_detect_replacement_core i_dut (.*);

    srrip_stream_detect_replacement_core_checker i_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_command,
        .i_set_index, .i_way_index, .i_address, .i_was_hit,
        .i_out_valid(o_out_valid), .i_out_stall, .i_victim_way(o_victim_way),
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_victims_checked(victims_checked), .o_requests(requests)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver stall pattern: stall_mode is redrawn at random and sets how often i_out_stall is high
    always @(negedge i_clk) begin
        if (($urandom_range(0, 63)) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL srrip_stream_detect_replacement_core");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx == REG_STRIDE) cur_stride = val[STRIDE_W-1:0];
    endtask

    task automatic wait_quiet();
        i_in_valid = 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_request(logic cmd, logic [SET_IDX_W-1:0] set_i,
                                logic [WAY_IDX_W-1:0] way_i, logic [IN_ADDR_W-1:0] addr,
                                logic hit);
        bit taken;
        i_command = cmd; i_set_index = set_i; i_way_index = way_i;
        i_address = addr; i_was_hit = hit; i_in_valid = 1'b1;
        if (cmd != CMD_VICTIM) sent_addr[int'({set_i, way_i})] = addr;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
            @(negedge i_clk);
        end
    endtask

    task automatic random_request(int fill_pct, int victim_pct);
        logic [SET_IDX_W-1:0] set_i;
        logic [WAY_IDX_W-1:0] way_i;
        logic [IN_ADDR_W-1:0] addr;
        logic                 hit;
        int                   key;
        set_i = ($urandom_range(0, 9) < 8) ? SET_IDX_W'($urandom_range(0, 5))
                                          : SET_IDX_W'($urandom);
        if ($urandom_range(0, 19) == 0) set_i = '1;
        way_i = WAY_IDX_W'($urandom);
        key = int'({set_i, way_i});
        if ($urandom_range(0, 99) < victim_pct) begin
            send_request(CMD_VICTIM, set_i, way_i, IN_ADDR_W'({$urandom, $urandom}),
                         1'($urandom));
        end else begin
            hit = ($urandom_range(0, 99) >= fill_pct);
            if (sent_addr.exists(key) && $urandom_range(0, 9) < 7)
                addr = $urandom_range(0, 1) ? sent_addr[key] + cur_stride
                                            : sent_addr[key] - cur_stride;
            else if ($urandom_range(0, 3) == 0)
                addr = IN_ADDR_W'($urandom_range(0, 4096));
            else
                addr = IN_ADDR_W'({$urandom, $urandom});
            send_request(1'b1, set_i, way_i, addr, hit);
        end
        if ($urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic random_phase(int n, int fill_pct, int victim_pct);
        for (int i = 0; i < n; i++) random_request(fill_pct, victim_pct);
        phase_count++;
    endtask

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_command = 1'b0; i_set_index = '0;
        i_way_index = '0; i_address = '0; i_was_hit = 1'b0; i_out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        stall_mode = 0; idle_cycles = 0; phase_count = 0; cur_stride = STRIDE_RST;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: fresh set, fill near, streaming detection, aging, extremes
        send_request(CMD_VICTIM, '0, '0, '0, 1'b0);
        send_request(1'b1, '0, '0, '0, 1'b0);
        send_request(CMD_VICTIM, '0, '1, '1, 1'b1);
        send_request(1'b1, '1, '1, '1, 1'b1);
        send_request(1'b1, '1, '1, {IN_ADDR_W{1'b1}} - IN_ADDR_W'(64), 1'b1);
        send_request(1'b1, '1, '1, {IN_ADDR_W{1'b1}} - IN_ADDR_W'(128), 1'b1);
        send_request(1'b1, '1, '1, {IN_ADDR_W{1'b1}} - IN_ADDR_W'(192), 1'b1);
        send_request(1'b1, '1, '1, 48'h1234, 1'b0);
        send_request(CMD_VICTIM, '1, '0, '0, 1'b0);
        for (int w = 0; w < 16; w++) send_request(1'b1, 11'd3, WAY_IDX_W'(w), 48'd64, 1'b1);
        send_request(CMD_VICTIM, 11'd3, '0, '0, 1'b0);
        send_request(CMD_VICTIM, 11'd3, '0, '0, 1'b0);
        random_phase(200, 30, 35);

        wait_quiet();
        write_reg(REG_STRIDE, 32'd1);
        write_reg(REG_THRESHOLD, 32'd0);
        write_reg(REG_PERIOD, 32'd1);
        random_phase(40, 10, 40);

        wait_quiet();
        write_reg(REG_STRIDE, 32'd4096);
        write_reg(REG_THRESHOLD, 32'd3);
        write_reg(REG_PERIOD, 32'd65536);
        random_phase(220, 25, 35);

        wait_quiet();
        write_reg(REG_STRIDE, 32'd64);
        write_reg(REG_THRESHOLD, 32'd1);
        write_reg(REG_PERIOD, 32'd20);
        random_phase(220, 20, 35);

        wait_quiet();
        write_reg(REG_STRIDE, 32'd0);
        write_reg(REG_THRESHOLD, 32'd2);
        write_reg(REG_PERIOD, 32'd4);
        random_phase(60, 15, 35);

        wait_quiet();
        $display("Covered %0d requests over %0d config phases; %0d victim results checked.",
                 requests, phase_count, victims_checked);
        if (fail_count == 0) begin
            $display("PASS srrip_stream_detect_replacement_core");
        end else begin
            $display("FAIL srrip_stream_detect_replacement_core");
        end
        $finish;
    end
endmodule

/* srrip_stream_detect_replacement_core.f */
+incdir+rtl/core
rtl/core/srsd_pkg.sv
rtl/core/srsd_ram.sv
rtl/core/srsd_front.sv
rtl/core/srsd_back.sv
rtl/core/srrip_stream_detect_replacement_core.sv
tb/srrip_stream_detect_replacement_core_checker.sv
tb/srrip_stream_detect_replacement_core_tb.sv
